FILE: src/flsa_pkg.sv
// flsa_pkg: shared types and constants of the free-list slot allocator
// used by flsa_ctrl, flsa_datapath and the top level; no dependencies

package flsa_pkg;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 7;
  localparam int DATA_W   = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: src/flsa_ctrl.sv
// flsa_ctrl: controller state machine of the slot allocator
// depends on flsa_pkg; drives flsa_datapath through ctrl_t

module flsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  flsa_pkg::stat_t stat,
  output flsa_pkg::ctrl_t ctrl
);

  flsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flsa_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = flsa_pkg::S_EXEC;
      end
      flsa_pkg::S_EXEC: begin
        state_nxt = flsa_pkg::S_FIN;
      end
      flsa_pkg::S_FIN: begin
        if (stat.out_free) state_nxt = in_tvalid ? flsa_pkg::S_EXEC : flsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = flsa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    ctrl.exec   = 1'b0;
    ctrl.finish = 1'b0;
    unique case (state_r)
      flsa_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      flsa_pkg::S_EXEC: begin
        ctrl.exec = 1'b1;
      end
      flsa_pkg::S_FIN: begin
        in_tready   = stat.out_free;
        ctrl.finish = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    ctrl.load = in_tvalid && in_tready;
  end

endmodule

FILE: src/flsa_datapath.sv
// flsa_datapath: free list, in-use bits, tag store, counters and output register
// depends on flsa_pkg; sequenced by flsa_ctrl

module flsa_datapath #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flsa_pkg::ctrl_t               ctrl,
  output flsa_pkg::stat_t               stat,
  input  logic [flsa_pkg::DATA_W-1:0]   in_tdata,
  input  logic                          cfg_wen,
  input  logic [flsa_pkg::CAP_W-1:0]    cfg_wdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [flsa_pkg::DATA_W-1:0]   out_tdata
);

  localparam int LW     = $clog2(SLOTS + 1);
  localparam int AW     = $clog2(SLOTS);
  localparam int VSLOTS = (SLOTS < 64) ? SLOTS : 64;
  localparam int VW     = $clog2(VSLOTS);
  localparam int CMPW   = (LW > flsa_pkg::CAP_W) ? LW : flsa_pkg::CAP_W;
  localparam int SW     = (LW > flsa_pkg::SLOT_W) ? LW : flsa_pkg::SLOT_W;
  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  // latched word
  logic [flsa_pkg::CMD_W-1:0]  cmd_r;
  logic [flsa_pkg::SLOT_W-1:0] slot_r;
  logic [flsa_pkg::TAG_W-1:0]  tag_r;

  logic [flsa_pkg::CAP_W-1:0] capacity_r;
  logic [LW-1:0]              head_r;
  logic [LW-1:0]              hwm_r;
  logic [LW-1:0]              count_r;
  logic [VSLOTS-1:0]          valid_r;

  logic [LW-1:0]              link_mem [SLOTS];
  logic [flsa_pkg::TAG_W-1:0] class_mem [VSLOTS];
  logic [LW-1:0]              link_rd_r;
  logic [flsa_pkg::TAG_W-1:0] class_rd_r;

  logic [flsa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [flsa_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [flsa_pkg::TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic                          res_use_class_r, res_use_class_nxt;
  logic                          res_pop_r;
  logic                          res_fresh_r;

  logic                          out_valid_r;
  logic [flsa_pkg::DATA_W-1:0]   out_data_r;

  logic in_range, valid_hit, list_empty, at_cap, alloc_ok, free_ok, head_vis;

  assign in_range   = SW'(slot_r) < SW'(SLOTS);
  assign valid_hit  = in_range && valid_r[VW'(slot_r)];
  assign list_empty = (head_r == NONE);
  assign at_cap     = CMPW'(count_r) >= CMPW'(capacity_r);
  assign alloc_ok   = (cmd_r == flsa_pkg::CMD_ALLOC) && !list_empty && !at_cap;
  assign free_ok    = (cmd_r == flsa_pkg::CMD_FREE) && valid_hit;
  assign head_vis   = head_r < LW'(VSLOTS);

  always_comb begin
    res_status_nxt    = flsa_pkg::ST_NOT_IN_USE;
    res_slot_nxt      = slot_r;
    res_tag_nxt       = '0;
    res_use_class_nxt = 1'b0;
    case (cmd_r)
      flsa_pkg::CMD_ALLOC: begin
        if (alloc_ok) begin
          res_status_nxt = flsa_pkg::ST_OK;
          res_slot_nxt   = flsa_pkg::SLOT_W'(head_r);
          res_tag_nxt    = tag_r;
        end else begin
          res_status_nxt = flsa_pkg::ST_FULL;
          res_slot_nxt   = '0;
        end
      end
      flsa_pkg::CMD_LOOKUP: begin
        if (valid_hit) begin
          res_status_nxt    = flsa_pkg::ST_OK;
          res_use_class_nxt = 1'b1;
        end
      end
      flsa_pkg::CMD_FREE: begin
        if (valid_hit) res_status_nxt = flsa_pkg::ST_OK;
      end
      default: begin
        res_status_nxt = flsa_pkg::ST_NOT_IN_USE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= flsa_pkg::CAP_RESET;
      head_r      <= '0;
      hwm_r       <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) capacity_r <= cfg_wdata;
      if (ctrl.exec && alloc_ok) begin
        count_r <= count_r + LW'(1);
        if (head_vis) valid_r[VW'(head_r)] <= 1'b1;
        if (head_r == hwm_r) hwm_r <= hwm_r + LW'(1);
      end
      if (ctrl.exec && free_ok) begin
        valid_r[VW'(slot_r)] <= 1'b0;
        head_r               <= LW'(slot_r);
        if (count_r != '0) count_r <= count_r - LW'(1);
      end
      if (ctrl.finish && res_pop_r) begin
        head_r <= res_fresh_r ? head_r + LW'(1) : link_rd_r;
      end
      if (ctrl.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_tdata[1:0];
      slot_r <= in_tdata[7:2];
      tag_r  <= in_tdata[23:8];
    end
    if (ctrl.exec) begin
      res_status_r    <= res_status_nxt;
      res_slot_r      <= res_slot_nxt;
      res_tag_r       <= res_tag_nxt;
      res_use_class_r <= res_use_class_nxt;
      res_pop_r       <= alloc_ok;
      res_fresh_r     <= (head_r == hwm_r);
    end
    if (ctrl.finish) begin
      out_data_r <= {(res_use_class_r ? class_rd_r : res_tag_r), res_slot_r, res_status_r};
    end
  end

  // link store, read for the pop and written on free
  always_ff @(posedge clk) begin
    if (ctrl.exec && free_ok) link_mem[AW'(slot_r)] <= head_r;
    link_rd_r <= link_mem[AW'(head_r)];
  end

  // tag store
  always_ff @(posedge clk) begin
    if (ctrl.exec && alloc_ok && head_vis) class_mem[VW'(head_r)] <= tag_r;
    class_rd_r <= class_mem[VW'(slot_r)];
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

FILE: src/free_list_slot_allocator.sv
// free_list_slot_allocator: top level of the slot allocator
// instantiates flsa_ctrl and flsa_datapath; uses flsa_pkg
//
// Hands out slots of a fixed pool from a last-in first-out free list.
// Input channel in_*: one word per command (allocate, lookup, free).
// Result channel out_*: exactly one word per accepted command, in order.
// Configuration: cfg_wen/cfg_wdata write the capacity register (reset 64),
// which the user must do only while no command is in flight; the block
// does not enforce this. A word is latched, its result is registered in
// the execute state and loaded into the output register in the finish
// state. An allocate's pop reads the next link from the link memory in the
// execute state; the head is set in the finish state. A new command is
// taken in the cycle the previous result enters the output register.
// Reset: the free list holds every slot in order, no slot is in use, the
// count is zero; no clearing pass is needed and the block is ready at once.
// Receiver stall: the output register holds its word; after one more
// command has been executed the input side stalls until out_tready.

module free_list_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[1:0], slot[7:2], class_tag[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], slot_out[7:2], class_out[23:8]
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata
);

  flsa_pkg::ctrl_t ctrl;
  flsa_pkg::stat_t stat;

  flsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  flsa_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/flsa_checker.sv
// flsa_checker: port-level checks of free_list_slot_allocator
// bound to the top level below; depends on flsa_pkg

module flsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // no command is taken while the previous one executes
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= flsa_pkg::ST_NOT_IN_USE)
    else $error("undefined status code");

  // a failed allocate returns no slot and no tag
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == flsa_pkg::ST_FULL |-> out_tdata[23:2] == 22'd0)
    else $error("failed allocate with nonzero slot or tag");

endmodule

bind free_list_slot_allocator flsa_checker u_flsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/tb_free_list_slot_allocator.sv
`timescale 1ns / 1ps
// tb_free_list_slot_allocator: self-checking bench for the free-list slot allocator
// drives allocate/lookup/free words with random gaps and stalls, predicts each result
// from its own pool model; depends on flsa_pkg and free_list_slot_allocator

module tb_free_list_slot_allocator;

  localparam int POOL_SLOTS = 64;
  localparam logic [6:0] LINK_NONE = 7'd64;
  localparam logic [flsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [flsa_pkg::TAG_W-1:0]  class_tag;
    logic [flsa_pkg::SLOT_W-1:0] slot;
    logic [flsa_pkg::CMD_W-1:0]  cmd;
  } cmd_word_t;

  typedef struct packed {
    logic [flsa_pkg::TAG_W-1:0]    class_out;
    logic [flsa_pkg::SLOT_W-1:0]   slot_out;
    logic [flsa_pkg::STATUS_W-1:0] status;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  free_list_slot_allocator #(.SLOTS(POOL_SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // pool model
  logic [6:0]                 link_mem [POOL_SLOTS];
  logic                       slot_in_use [POOL_SLOTS];
  logic [flsa_pkg::TAG_W-1:0] tag_mem [POOL_SLOTS];
  logic [6:0]                 free_head;
  logic [6:0]                 in_use_count;
  logic [flsa_pkg::CAP_W-1:0] capacity;

  cmd_word_t    pending_words [$];
  result_word_t expected_results [$];
  int unsigned  words_queued = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         in_taken = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic result_word_t allocator_result(cmd_word_t w);
    result_word_t r;
    logic [6:0] got;
    r = '0;
    r.status = flsa_pkg::ST_NOT_IN_USE;
    r.slot_out = w.slot;
    case (w.cmd)
      flsa_pkg::CMD_ALLOC: begin
        r.slot_out = '0;
        if (free_head >= LINK_NONE || in_use_count >= capacity) begin
          r.status = flsa_pkg::ST_FULL;
        end else begin
          got = free_head;
          free_head = link_mem[got[5:0]];
          link_mem[got[5:0]] = LINK_NONE;
          slot_in_use[got[5:0]] = 1'b1;
          tag_mem[got[5:0]] = w.class_tag;
          in_use_count = in_use_count + 7'd1;
          r.status = flsa_pkg::ST_OK;
          r.slot_out = got[5:0];
          r.class_out = w.class_tag;
        end
      end
      flsa_pkg::CMD_LOOKUP: begin
        if (slot_in_use[w.slot]) begin
          r.status = flsa_pkg::ST_OK;
          r.class_out = tag_mem[w.slot];
        end
      end
      flsa_pkg::CMD_FREE: begin
        if (slot_in_use[w.slot]) begin
          slot_in_use[w.slot] = 1'b0;
          link_mem[w.slot] = free_head;
          free_head = {1'b0, w.slot};
          if (in_use_count != 0) in_use_count = in_use_count - 7'd1;
          r.status = flsa_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_words.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    result_word_t exp_r;
    result_word_t got_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      in_taken <= rst_n && in_tvalid && in_tready;
      if (rst_n && out_tvalid && out_tready) begin
        got_r = out_tdata;
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
            mismatches++;
          end
          if (got_r.slot_out !== exp_r.slot_out) begin
            $error("slot_out: expected %0d, got %0d", exp_r.slot_out, got_r.slot_out);
            mismatches++;
          end
          if (got_r.class_out !== exp_r.class_out) begin
            $error("class_out: expected %h, got %h", exp_r.class_out, got_r.class_out);
            mismatches++;
          end
        end
      end
      if (rst_n && in_tvalid && in_tready) begin
        expected_results.push_back(allocator_result(cmd_word_t'(in_tdata)));
      end
    end
  end

  task automatic push_word(logic [flsa_pkg::CMD_W-1:0] cmd,
                           logic [flsa_pkg::SLOT_W-1:0] slot,
                           logic [flsa_pkg::TAG_W-1:0] tag);
    cmd_word_t w;
    w.cmd = cmd;
    w.slot = slot;
    w.class_tag = tag;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen < words_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [flsa_pkg::CAP_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    capacity = value;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  task automatic push_random(int count, bit fill_only);
    int unsigned pick;
    int unsigned hot;
    bit filling;
    logic [flsa_pkg::CMD_W-1:0] cmd;
    logic [flsa_pkg::SLOT_W-1:0] slot;
    logic [flsa_pkg::TAG_W-1:0] tag;
    hot = (capacity > 60) ? 63 : capacity + 3;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) filling = fill_only || $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < (filling ? 55 : 20)) cmd = flsa_pkg::CMD_ALLOC;
      else if (pick < (filling ? 80 : 45)) cmd = flsa_pkg::CMD_LOOKUP;
      else if (pick < 96) cmd = flsa_pkg::CMD_FREE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(3) != 0) slot = flsa_pkg::SLOT_W'($urandom_range(hot));
      else slot = flsa_pkg::SLOT_W'($urandom_range(63));
      case ($urandom_range(9))
        0: tag = '0;
        1: tag = '1;
        default: tag = flsa_pkg::TAG_W'($urandom_range(16'hffff));
      endcase
      push_word(cmd, slot, tag);
    end
  endtask

  // capacity and idling mode, then half the words, a full pause until every result is back, then the rest
  task automatic run_phase(int mode, logic [flsa_pkg::CAP_W-1:0] cap, int count,
                           bit fill_only);
    write_capacity(cap);
    set_idling(mode);
    @(posedge clk);
    push_random(count / 2, fill_only);
    wait_drained();
    @(posedge clk);
    push_random(count - count / 2, fill_only);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      link_mem[i] = 7'(i + 1);
      slot_in_use[i] = 1'b0;
      tag_mem[i] = '0;
    end
    free_head = '0;
    in_use_count = '0;
    capacity = flsa_pkg::CAP_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset capacity
    set_idling(0);
    @(posedge clk);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd0, 16'h0000);
    push_word(flsa_pkg::CMD_FREE, 6'd63, 16'hffff);
    push_word(flsa_pkg::CMD_ALLOC, 6'd63, 16'h0000);
    push_word(flsa_pkg::CMD_ALLOC, 6'd0, 16'hffff);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd0, 16'h0000);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd1, 16'h0000);
    push_word(flsa_pkg::CMD_FREE, 6'd0, 16'h0000);
    push_word(flsa_pkg::CMD_FREE, 6'd0, 16'h0000);
    push_word(flsa_pkg::CMD_ALLOC, 6'd0, 16'ha5a5);
    push_word(CMD_UNUSED, 6'd63, 16'hffff);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd63, 16'h5a5a);
    push_word(flsa_pkg::CMD_FREE, 6'd1, 16'h0000);
    push_word(flsa_pkg::CMD_FREE, 6'd0, 16'h0000);
    wait_drained();

    // zero capacity blocks every allocate
    write_capacity(7'd0);
    @(posedge clk);
    push_word(flsa_pkg::CMD_ALLOC, 6'd0, 16'h1234);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd0, 16'h0000);
    wait_drained();

    // capacity of one
    write_capacity(7'd1);
    @(posedge clk);
    push_word(flsa_pkg::CMD_ALLOC, 6'd0, 16'h8001);
    push_word(flsa_pkg::CMD_ALLOC, 6'd0, 16'h7ffe);
    push_word(flsa_pkg::CMD_LOOKUP, 6'd0, 16'h0000);
    push_word(flsa_pkg::CMD_FREE, 6'd0, 16'h0000);
    wait_drained();

    // random phases; capacity drops below the in-use count after the fill
    run_phase(0, 7'd127, 136, 1'b0);
    run_phase(1, 7'd64, 136, 1'b1);
    run_phase(2, 7'd17, 136, 1'b0);
    run_phase(3, 7'd3, 136, 1'b0);
    run_phase(0, 7'd0, 40, 1'b0);
    run_phase(1, 7'd1, 136, 1'b0);
    run_phase(2, 7'($urandom_range(2, 63)), 136, 1'b0);
    run_phase(3, 7'd127, 136, 1'b1);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/flsa_pkg.sv
src/flsa_ctrl.sv
src/flsa_datapath.sv
src/free_list_slot_allocator.sv
src/flsa_checker.sv
tb/sv/tb_free_list_slot_allocator.sv
